// ===== rtl/imdr_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the IMU dead reckoning unit.
`default_nettype none
package imdr_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACC_BIAS_X  = 3'd0,
        REG_ACC_BIAS_Y  = 3'd1,
        REG_ACC_BIAS_Z  = 3'd2,
        REG_GYRO_BIAS_X = 3'd3,
        REG_GYRO_BIAS_Y = 3'd4,
        REG_GYRO_BIAS_Z = 3'd5,
        REG_GRAVITY_Z   = 3'd6
    } t_reg_idx;

    localparam logic signed [31:0] GRAVITY_RESET = 32'sd642865;
    localparam logic signed [31:0] ONE_Q30       = 32'sh4000_0000;

    // one sample with its previous accel and rate, as queued to the back end
    typedef struct packed {
        logic        [24:0] step_time;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] pacc_x;
        logic signed [31:0] pacc_y;
        logic signed [31:0] pacc_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] prate_x;
        logic signed [31:0] prate_y;
        logic signed [31:0] prate_z;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
        logic signed [31:0] r;
        if (x > 80'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -80'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [79:0] x);
        logic signed [47:0] r;
        if (x > 80'sd140737488355327) begin
            r = 48'sh7fff_ffff_ffff;
        end else if (x < -80'sd140737488355328) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/imu_midpoint_dead_reckoning_unit.sv =====
// Top level of the IMU mid-point dead reckoning unit.
//  channel | direction | handshake            | payload
//  sample  | in        | i_valid / o_ready    | step time, accel, rate
//  result  | out       | o_valid / i_ready    | quaternion, position, velocity
//  config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
// The back takes one sample at a time: a prep state, 61 products through one
// shared multiplier with a multiply and an accumulate state each, an output
// state and a wait state; it takes the next sample only when back in idle.
// A two-entry queue lets the front take samples while the back works.
// The back holds in its output state while an earlier result is not taken.
// Reset is synchronous, active low; it restores identity attitude.
`default_nettype none
module imu_midpoint_dead_reckoning_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [24:0]         i_step_time,
    input  wire logic signed [31:0]  i_accel_x,
    input  wire logic signed [31:0]  i_accel_y,
    input  wire logic signed [31:0]  i_accel_z,
    input  wire logic signed [31:0]  i_rate_x,
    input  wire logic signed [31:0]  i_rate_y,
    input  wire logic signed [31:0]  i_rate_z,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [31:0]       o_quat_w,
    output logic signed [31:0]       o_quat_x,
    output logic signed [31:0]       o_quat_y,
    output logic signed [31:0]       o_quat_z,
    output logic signed [47:0]       o_pos_x,
    output logic signed [47:0]       o_pos_y,
    output logic signed [47:0]       o_pos_z,
    output logic signed [31:0]       o_vel_x,
    output logic signed [31:0]       o_vel_y,
    output logic signed [31:0]       o_vel_z,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data
);
    import imdr_pkg::*;

    t_sample w_qd;
    t_result w_res;
    logic w_qv, w_qr;
    logic signed [31:0] w_abx, w_aby, w_abz, w_gbx, w_gby, w_gbz, w_gz;

    imdr_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_ab_x(w_abx), .o_ab_y(w_aby), .o_ab_z(w_abz),
        .o_gb_x(w_gbx), .o_gb_y(w_gby), .o_gb_z(w_gbz), .o_grav_z(w_gz)
    );

    imdr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_step_time(i_step_time), .i_accel_x(i_accel_x), .i_accel_y(i_accel_y),
        .i_accel_z(i_accel_z), .i_rate_x(i_rate_x), .i_rate_y(i_rate_y),
        .i_rate_z(i_rate_z), .o_q_valid(w_qv), .i_q_ready(w_qr), .o_q_data(w_qd)
    );

    imdr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_ready(w_qr),
        .i_q_data(w_qd), .i_ab_x(w_abx), .i_ab_y(w_aby), .i_ab_z(w_abz),
        .i_gb_x(w_gbx), .i_gb_y(w_gby), .i_gb_z(w_gbz), .i_grav_z(w_gz),
        .o_valid(o_valid), .i_ready(i_ready), .o_result(w_res)
    );

    assign o_quat_w = w_res.quat_w;
    assign o_quat_x = w_res.quat_x;
    assign o_quat_y = w_res.quat_y;
    assign o_quat_z = w_res.quat_z;
    assign o_pos_x  = w_res.pos_x;
    assign o_pos_y  = w_res.pos_y;
    assign o_pos_z  = w_res.pos_z;
    assign o_vel_x  = w_res.vel_x;
    assign o_vel_y  = w_res.vel_y;
    assign o_vel_z  = w_res.vel_z;
endmodule
`default_nettype wire

// ===== rtl/imdr_front.sv =====
// Front end: accepts samples, substitutes the first sample as previous, keeps history.
`default_nettype none
module imdr_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [24:0]           i_step_time,
    input  wire logic signed [31:0]    i_accel_x,
    input  wire logic signed [31:0]    i_accel_y,
    input  wire logic signed [31:0]    i_accel_z,
    input  wire logic signed [31:0]    i_rate_x,
    input  wire logic signed [31:0]    i_rate_y,
    input  wire logic signed [31:0]    i_rate_z,
    output logic                       o_q_valid,
    input  wire logic                  i_q_ready,
    output imdr_pkg::t_sample          o_q_data
);
    import imdr_pkg::*;

    // two-entry queue
    t_sample r_q [2];
    logic    r_wp, r_rp;
    logic [1:0] r_cnt;
    logic    r_seen;
    logic signed [31:0] r_pa [3];
    logic signed [31:0] r_pr [3];
    t_sample n_s;
    logic    w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_data  = r_q[r_rp];

    always_comb begin
        n_s.step_time = i_step_time;
        n_s.acc_x  = i_accel_x;
        n_s.acc_y  = i_accel_y;
        n_s.acc_z  = i_accel_z;
        n_s.rate_x = i_rate_x;
        n_s.rate_y = i_rate_y;
        n_s.rate_z = i_rate_z;
        n_s.pacc_x  = r_seen ? r_pa[0] : i_accel_x;
        n_s.pacc_y  = r_seen ? r_pa[1] : i_accel_y;
        n_s.pacc_z  = r_seen ? r_pa[2] : i_accel_z;
        n_s.prate_x = r_seen ? r_pr[0] : i_rate_x;
        n_s.prate_y = r_seen ? r_pr[1] : i_rate_y;
        n_s.prate_z = r_seen ? r_pr[2] : i_rate_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
            r_seen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= '0;
                r_pr[i] <= '0;
            end
        end else begin
            if (w_push) begin
                r_q[r_wp] <= n_s;
                r_wp      <= ~r_wp;
                r_seen    <= 1'b1;
                r_pa[0] <= i_accel_x;
                r_pa[1] <= i_accel_y;
                r_pa[2] <= i_accel_z;
                r_pr[0] <= i_rate_x;
                r_pr[1] <= i_rate_y;
                r_pr[2] <= i_rate_z;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imdr_back.sv =====
// Back end: sequencer over one shared multiplier that integrates attitude, velocity, position.
`default_nettype none
module imdr_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_ready,
    input  wire imdr_pkg::t_sample     i_q_data,
    input  wire logic signed [31:0]    i_ab_x,
    input  wire logic signed [31:0]    i_ab_y,
    input  wire logic signed [31:0]    i_ab_z,
    input  wire logic signed [31:0]    i_gb_x,
    input  wire logic signed [31:0]    i_gb_y,
    input  wire logic signed [31:0]    i_gb_z,
    input  wire logic signed [31:0]    i_grav_z,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output imdr_pkg::t_result          o_result
);
    import imdr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_WAIT, S_ACC, S_OUT
    } t_state;

    // micro-op numbering over the whole step
    localparam logic [6:0] OP_H    = 7'd0;   // 3 ops: half angles
    localparam logic [6:0] OP_DT2  = 7'd3;   // 1 op
    localparam logic [6:0] OP_RM0  = 7'd4;   // 9 ops: rotation products, old q
    localparam logic [6:0] OP_RV0  = 7'd13;  // 9 ops: matrix times v0
    localparam logic [6:0] OP_Q    = 7'd22;  // 12 ops: quaternion update
    localparam logic [6:0] OP_RM1  = 7'd34;  // 9 ops
    localparam logic [6:0] OP_RV1  = 7'd43;  // 9 ops
    localparam logic [6:0] OP_VD   = 7'd52;  // 3 ops: v*dt
    localparam logic [6:0] OP_AD2  = 7'd55;  // 3 ops: a*dt2
    localparam logic [6:0] OP_AD   = 7'd58;  // 3 ops: a*dt
    localparam logic [6:0] OP_LAST = 7'd60;

    t_state r_state;
    logic [6:0] r_op;
    t_sample r_s;
    logic signed [31:0] r_q [4];
    logic signed [47:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [32:0] r_om [3];
    logic signed [31:0] r_h [3];
    logic signed [31:0] r_v0 [3];
    logic signed [31:0] r_v1 [3];
    logic signed [33:0] r_pp [9];     // xx yy zz xy xz yz wx wy wz
    logic signed [31:0] r_m [9];
    logic signed [47:0] r_a0 [3];
    logic signed [47:0] r_a1 [3];
    logic signed [47:0] r_a [3];
    logic [26:0] r_dt2;
    logic signed [63:0] r_acc [4];
    logic signed [49:0] r_pd [3];

    logic signed [34:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [81:0] r_prod;
    logic [6:0] r_pop;
    logic [6:0] w_k;
    logic signed [63:0] w_r30;

    // operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_k  = '0;
        if (r_op < OP_DT2) begin
            w_k = r_op - OP_H;
            w_ma = 35'(r_om[w_k[1:0]]);
            w_mb = 33'($signed({1'b0, r_s.step_time}));
        end else if (r_op == OP_DT2) begin
            w_ma = 35'($signed({1'b0, r_s.step_time}));
            w_mb = 33'($signed({1'b0, r_s.step_time}));
        end else if (r_op < OP_RV0 || (r_op >= OP_RM1 && r_op < OP_RV1)) begin
            w_k = (r_op < OP_RV0) ? r_op - OP_RM0 : r_op - OP_RM1;
            unique case (w_k[3:0])
                4'd0: begin w_ma = 35'(r_q[1]); w_mb = 33'(r_q[1]); end
                4'd1: begin w_ma = 35'(r_q[2]); w_mb = 33'(r_q[2]); end
                4'd2: begin w_ma = 35'(r_q[3]); w_mb = 33'(r_q[3]); end
                4'd3: begin w_ma = 35'(r_q[1]); w_mb = 33'(r_q[2]); end
                4'd4: begin w_ma = 35'(r_q[1]); w_mb = 33'(r_q[3]); end
                4'd5: begin w_ma = 35'(r_q[2]); w_mb = 33'(r_q[3]); end
                4'd6: begin w_ma = 35'(r_q[0]); w_mb = 33'(r_q[1]); end
                4'd7: begin w_ma = 35'(r_q[0]); w_mb = 33'(r_q[2]); end
                default: begin w_ma = 35'(r_q[0]); w_mb = 33'(r_q[3]); end
            endcase
        end else if (r_op < OP_Q || (r_op >= OP_RV1 && r_op < OP_VD)) begin
            w_k = (r_op < OP_Q) ? r_op - OP_RV0 : r_op - OP_RV1;
            w_ma = 35'(r_m[w_k[3:0]]);
            unique case (w_k[3:0])
                4'd0, 4'd3, 4'd6: w_mb = 33'((r_op < OP_Q) ? r_v0[0] : r_v1[0]);
                4'd1, 4'd4, 4'd7: w_mb = 33'((r_op < OP_Q) ? r_v0[1] : r_v1[1]);
                default:          w_mb = 33'((r_op < OP_Q) ? r_v0[2] : r_v1[2]);
            endcase
        end else if (r_op < OP_RM1) begin
            w_k = r_op - OP_Q;
            unique case (w_k[3:0])
                4'd0:  begin w_ma = 35'(r_q[1]); w_mb = 33'(r_h[0]); end
                4'd1:  begin w_ma = 35'(r_q[2]); w_mb = 33'(r_h[1]); end
                4'd2:  begin w_ma = 35'(r_q[3]); w_mb = 33'(r_h[2]); end
                4'd3:  begin w_ma = 35'(r_q[0]); w_mb = 33'(r_h[0]); end
                4'd4:  begin w_ma = 35'(r_q[2]); w_mb = 33'(r_h[2]); end
                4'd5:  begin w_ma = 35'(r_q[3]); w_mb = 33'(r_h[1]); end
                4'd6:  begin w_ma = 35'(r_q[0]); w_mb = 33'(r_h[1]); end
                4'd7:  begin w_ma = 35'(r_q[1]); w_mb = 33'(r_h[2]); end
                4'd8:  begin w_ma = 35'(r_q[3]); w_mb = 33'(r_h[0]); end
                4'd9:  begin w_ma = 35'(r_q[0]); w_mb = 33'(r_h[2]); end
                4'd10: begin w_ma = 35'(r_q[1]); w_mb = 33'(r_h[1]); end
                default: begin w_ma = 35'(r_q[2]); w_mb = 33'(r_h[0]); end
            endcase
        end else if (r_op < OP_AD2) begin
            w_k = r_op - OP_VD;
            w_ma = 35'(r_vel[w_k[1:0]]);
            w_mb = 33'($signed({1'b0, r_s.step_time}));
        end else if (r_op < OP_AD) begin
            w_k = r_op - OP_AD2;
            w_ma = 35'(r_a[w_k[1:0]]);
            w_mb = 33'($signed({6'b0, r_dt2}));
        end else begin
            w_k = r_op - OP_AD;
            w_ma = 35'(r_a[w_k[1:0]]);
            w_mb = 33'($signed({1'b0, r_s.step_time}));
        end
    end

    assign w_r30 = 64'((r_prod + 82'sd536870912) >>> 30);

    assign o_q_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        logic [6:0] k;
        logic signed [63:0] t;
        logic signed [79:0] wide;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            r_pop   <= '0;
            o_valid <= 1'b0;
            r_q[0] <= ONE_Q30;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_s     <= i_q_data;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_om[0] <= 33'((34'(r_s.prate_x) + 34'(r_s.rate_x)) >>> 1) - 33'(i_gb_x);
                    r_om[1] <= 33'((34'(r_s.prate_y) + 34'(r_s.rate_y)) >>> 1) - 33'(i_gb_y);
                    r_om[2] <= 33'((34'(r_s.prate_z) + 34'(r_s.rate_z)) >>> 1) - 33'(i_gb_z);
                    r_v0[0] <= sat32(80'(r_s.pacc_x) - 80'(i_ab_x));
                    r_v0[1] <= sat32(80'(r_s.pacc_y) - 80'(i_ab_y));
                    r_v0[2] <= sat32(80'(r_s.pacc_z) - 80'(i_ab_z));
                    r_v1[0] <= sat32(80'(r_s.acc_x) - 80'(i_ab_x));
                    r_v1[1] <= sat32(80'(r_s.acc_y) - 80'(i_ab_y));
                    r_v1[2] <= sat32(80'(r_s.acc_z) - 80'(i_ab_z));
                    for (int i = 0; i < 4; i++) begin
                        r_acc[i] <= '0;
                    end
                    r_op    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 82'(w_ma) * 82'(w_mb);
                    r_pop   <= r_op;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    k = r_pop;
                    if (k < OP_DT2) begin
                        wide = 80'((r_prod + 82'sd1024) >>> 11);
                        r_h[k[1:0]] <= sat32(wide);
                    end else if (k == OP_DT2) begin
                        r_dt2 <= 27'((r_prod + 82'sd8388608) >>> 24);
                    end else if (k < OP_RV0 || (k >= OP_RM1 && k < OP_RV1)) begin
                        k = (k < OP_RV0) ? k - OP_RM0 : k - OP_RM1;
                        r_pp[k[3:0]] <= w_r30[33:0];
                        if (k == 7'd8) begin
                            // build rotation matrix from the products
                            r_m[0] <= sat32(80'(ONE_Q30) - 80'sd2 * (80'(r_pp[1]) + 80'(r_pp[2])));
                            r_m[1] <= sat32(80'sd2 * (80'(r_pp[3]) - 80'(w_r30)));
                            r_m[2] <= sat32(80'sd2 * (80'(r_pp[4]) + 80'(r_pp[7])));
                            r_m[3] <= sat32(80'sd2 * (80'(r_pp[3]) + 80'(w_r30)));
                            r_m[4] <= sat32(80'(ONE_Q30) - 80'sd2 * (80'(r_pp[0]) + 80'(r_pp[2])));
                            r_m[5] <= sat32(80'sd2 * (80'(r_pp[5]) - 80'(r_pp[6])));
                            r_m[6] <= sat32(80'sd2 * (80'(r_pp[4]) - 80'(r_pp[7])));
                            r_m[7] <= sat32(80'sd2 * (80'(r_pp[5]) + 80'(r_pp[6])));
                            r_m[8] <= sat32(80'(ONE_Q30) - 80'sd2 * (80'(r_pp[0]) + 80'(r_pp[1])));
                        end
                    end else if (k < OP_Q || (k >= OP_RV1 && k < OP_VD)) begin
                        k = (k < OP_Q) ? k - OP_RV0 : k - OP_RV1;
                        t = r_acc[0] + w_r30;
                        if (k == 7'd2 || k == 7'd5 || k == 7'd8) begin
                            r_acc[0] <= '0;
                            if (r_pop < OP_Q) begin
                                if (k == 7'd2) r_a0[0] <= 48'(t);
                                else if (k == 7'd5) r_a0[1] <= 48'(t);
                                else r_a0[2] <= 48'(t) - 48'(i_grav_z);
                            end else begin
                                if (k == 7'd2) r_a1[0] <= 48'(t);
                                else if (k == 7'd5) r_a1[1] <= 48'(t);
                                else begin
                                    r_a1[2] <= 48'(t) - 48'(i_grav_z);
                                    r_a[0] <= 48'((49'(r_a0[0]) + 49'(r_a1[0])) >>> 1);
                                    r_a[1] <= 48'((49'(r_a0[1]) + 49'(r_a1[1])) >>> 1);
                                    r_a[2] <= 48'((49'(r_a0[2]) + 49'(t)
                                              - 49'(i_grav_z)) >>> 1);
                                end
                            end
                        end else begin
                            r_acc[0] <= t;
                        end
                    end else if (k < OP_RM1) begin
                        k = k - OP_Q;
                        // component index k/3, sign per the Hamilton product
                        if (k < 7'd3) begin
                            r_acc[0] <= r_acc[0] - w_r30;
                        end else if (k < 7'd6) begin
                            r_acc[1] <= (k == 7'd5) ? r_acc[1] - w_r30 : r_acc[1] + w_r30;
                        end else if (k < 7'd9) begin
                            r_acc[2] <= (k == 7'd7) ? r_acc[2] - w_r30 : r_acc[2] + w_r30;
                        end else begin
                            r_acc[3] <= (k == 7'd11) ? r_acc[3] - w_r30 : r_acc[3] + w_r30;
                        end
                        if (k == 7'd11) begin
                            // w*1 etc. in Q30 are exact: add the old q itself
                            r_q[0] <= sat32(80'(r_acc[0]) + 80'(r_q[0]));
                            r_q[1] <= sat32(80'(r_acc[1]) + 80'(r_q[1]));
                            r_q[2] <= sat32(80'(r_acc[2]) + 80'(r_q[2]));
                            r_q[3] <= sat32(80'(r_acc[3]) - 80'(w_r30) + 80'(r_q[3]));
                            r_acc[0] <= '0;
                        end
                    end else if (k < OP_AD2) begin
                        k = k - OP_VD;
                        r_pd[k[1:0]] <= 50'((r_prod + 82'sd8388608) >>> 24);
                    end else if (k < OP_AD) begin
                        k = k - OP_AD2;
                        wide = 80'(r_pos[k[1:0]]) + 80'(r_pd[k[1:0]])
                             + 80'((r_prod + 82'sd16777216) >>> 25);
                        r_pos[k[1:0]] <= sat48(wide);
                    end else begin
                        k = k - OP_AD;
                        wide = 80'(r_vel[k[1:0]]) + 80'((r_prod + 82'sd8388608) >>> 24);
                        r_vel[k[1:0]] <= sat32(wide);
                    end
                    if (r_pop == OP_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= r_pop + 7'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            if (r_state == S_OUT && (!o_valid || i_ready)) begin
                o_result.quat_w <= r_q[0];
                o_result.quat_x <= r_q[1];
                o_result.quat_y <= r_q[2];
                o_result.quat_z <= r_q[3];
                o_result.pos_x  <= r_pos[0];
                o_result.pos_y  <= r_pos[1];
                o_result.pos_z  <= r_pos[2];
                o_result.vel_x  <= r_vel[0];
                o_result.vel_y  <= r_vel[1];
                o_result.vel_z  <= r_vel[2];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imdr_cfg.sv =====
// Configuration register file: biases and gravity.
`default_nettype none
module imdr_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [imdr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                  i_cfg_data,
    output logic signed [31:0]                o_ab_x,
    output logic signed [31:0]                o_ab_y,
    output logic signed [31:0]                o_ab_z,
    output logic signed [31:0]                o_gb_x,
    output logic signed [31:0]                o_gb_y,
    output logic signed [31:0]                o_gb_z,
    output logic signed [31:0]                o_grav_z
);
    import imdr_pkg::*;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ab_x <= '0;
            o_ab_y <= '0;
            o_ab_z <= '0;
            o_gb_x <= '0;
            o_gb_y <= '0;
            o_gb_z <= '0;
            o_grav_z <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ACC_BIAS_X:  o_ab_x   <= i_cfg_data;
                REG_ACC_BIAS_Y:  o_ab_y   <= i_cfg_data;
                REG_ACC_BIAS_Z:  o_ab_z   <= i_cfg_data;
                REG_GYRO_BIAS_X: o_gb_x   <= i_cfg_data;
                REG_GYRO_BIAS_Y: o_gb_y   <= i_cfg_data;
                REG_GYRO_BIAS_Z: o_gb_z   <= i_cfg_data;
                REG_GRAVITY_Z:   o_grav_z <= i_cfg_data;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imdr_checker.sv =====
// Port-level checker for the dead reckoning unit, bound to the top level.
`default_nettype none
module imdr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_quat_w,
    input wire logic [47:0] o_pos_x
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat_w) && $stable(o_pos_x))
        else $error("result dropped while stalled");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_ready_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("not ready after reset");
endmodule

bind imu_midpoint_dead_reckoning_unit imdr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_quat_w(o_quat_w), .o_pos_x(o_pos_x)
);
`default_nettype wire
